// ===== rtl/sfv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfv_pkg
// shared types, frame layout constants and the crc-16/modbus byte update
// ----------------------------------------------------------------------------
package sfv_pkg;

    localparam int unsigned FrameLen   = 23;
    localparam int unsigned PayloadLen = 19;
    localparam int unsigned CountW     = 5;
    localparam int unsigned ByteW      = 8;
    localparam int unsigned CrcW       = 16;
    localparam int unsigned CfgAddrW   = 1;
    localparam int unsigned OutDataW   = 176;  // 170 field bits padded to bytes
    localparam int unsigned OutUsedW   = 170;

    localparam logic [CrcW-1:0]  CrcInit = 16'hFFFF;
    localparam logic [CrcW-1:0]  CrcPoly = 16'hA001;
    localparam logic [ByteW-1:0] StartDelimReset = 8'h02;
    localparam logic [ByteW-1:0] EndDelimReset   = 8'h03;

    // register indexes of the configuration port
    localparam logic [CfgAddrW-1:0] CfgStartDelim = 1'b0;
    localparam logic [CfgAddrW-1:0] CfgEndDelim   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_LEN   = 2'd1,
        ST_BAD_DELIM = 2'd2,
        ST_BAD_CRC   = 2'd3
    } t_frame_status;

    // one byte of crc-16/modbus, lsb first, eight shift steps
    function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
        logic [CrcW-1:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CrcPoly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sensor_frame_validator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_frame_validator
// checks delimited 23-byte sensor frames with crc-16/modbus and decodes them
// ----------------------------------------------------------------------------
// usage
//   slave stream: one received byte per transfer in s_axis_tdata, s_axis_tlast
//   on the final byte of a packet. every transfer updates the byte position;
//   payload bytes update the running crc and payload store in the same cycle.
//   master stream: one result per packet, registered, valid the cycle after
//   the transfer that carried tlast. non-ok results carry zeros in every
//   field but the status.
//   throughput: one byte per cycle unless s_axis_tready is low; the crc byte
//   update is eight shift steps unrolled between byte input and crc register.
//   stall: the result register holds while m_axis_tready is low; bytes keep
//   flowing whenever the result register is empty or being drained, and
//   s_axis_tready drops only while a result waits and the sink is stalled.
//   reset (synchronous, active low): delimiters return to 0x02 / 0x03, the
//   packet position restarts, no result is pending.
//   configuration: write i_cfg_we / i_cfg_addr / i_cfg_wdata while idle.
// ----------------------------------------------------------------------------
module sensor_frame_validator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [sfv_pkg::CfgAddrW-1:0]  i_cfg_addr,
    input  wire logic [sfv_pkg::ByteW-1:0]     i_cfg_wdata,
    // byte stream in
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
    input  wire logic                          s_axis_tlast,  // last_byte
    // result stream out
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [1:0] frame_status, [2] mode_flag, [9:3] device_id_head,
    // [73:10] device_id_tail, [81:74] node_id, [83:82] button_bits,
    // [89:84] battery_bits, [121:90] latitude, [153:122] longitude,
    // [169:154] ack_crc, [175:170] zero
    output logic [sfv_pkg::OutDataW-1:0]       m_axis_tdata
);
    import sfv_pkg::*;

    // configuration
    logic [ByteW-1:0] r_start_delim;
    logic [ByteW-1:0] r_end_delim;

    // packet state
    logic [CountW-1:0] r_count, n_count;
    logic [CrcW-1:0]   r_crc, n_crc;
    logic              r_start_ok, n_start_ok;
    logic [CrcW-1:0]   r_check, n_check;     // received crc, high then low
    logic [CrcW-1:0]   r_ack, n_ack;         // crc of the node id byte
    logic [ByteW-1:0]  r_payload [PayloadLen];

    // result register
    logic                r_m_valid;
    logic [OutDataW-1:0] r_m_data, n_m_data;

    logic              in_xfer;
    logic              last_xfer;
    logic              end_ok;
    logic              pl_we;
    logic [CountW-1:0] pl_idx;
    t_frame_status     status;

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign last_xfer     = in_xfer && s_axis_tlast;

    // payload bytes sit at positions 1 to 19
    assign pl_we  = in_xfer && (r_count >= CountW'(1)) && (r_count <= CountW'(PayloadLen));
    assign pl_idx = r_count - CountW'(1);

    assign end_ok = (r_count == CountW'(FrameLen - 1)) && (s_axis_tdata == r_end_delim);

    // per-byte state update
    always_comb begin
        n_count    = r_count;
        n_crc      = r_crc;
        n_start_ok = r_start_ok;
        n_check    = r_check;
        n_ack      = r_ack;
        if (r_count == '0) begin
            n_start_ok = (s_axis_tdata == r_start_delim);
        end else if (r_count <= CountW'(PayloadLen)) begin
            n_crc = crc_byte(r_crc, s_axis_tdata);
        end else if (r_count == CountW'(PayloadLen + 1)) begin
            n_check = {s_axis_tdata, r_check[7:0]};
        end else if (r_count == CountW'(PayloadLen + 2)) begin
            n_check = {r_check[15:8], s_axis_tdata};
        end
        // payload byte 9 is the node id; its ack crc is ready in advance
        if (r_count == CountW'(10)) begin
            n_ack = crc_byte(CrcInit, s_axis_tdata);
        end
        if (r_count != '1) begin
            n_count = r_count + CountW'(1);
        end
    end

    // status at the end of a packet: length, then delimiters, then crc
    always_comb begin
        if (r_count != CountW'(FrameLen - 1)) begin
            status = ST_BAD_LEN;
        end else if (!r_start_ok || !end_ok) begin
            status = ST_BAD_DELIM;
        end else if (r_crc != r_check) begin
            status = ST_BAD_CRC;
        end else begin
            status = ST_OK;
        end
    end

    // decoded result, fields zero unless the frame is good
    always_comb begin
        n_m_data = '0;
        n_m_data[1:0] = status;
        if (status == ST_OK) begin
            n_m_data[2]       = r_payload[0][7];
            n_m_data[9:3]     = r_payload[0][6:0];
            n_m_data[73:10]   = {r_payload[1], r_payload[2], r_payload[3], r_payload[4],
                                 r_payload[5], r_payload[6], r_payload[7], r_payload[8]};
            n_m_data[81:74]   = r_payload[9];
            n_m_data[83:82]   = r_payload[10][7:6];
            n_m_data[89:84]   = r_payload[10][5:0];
            n_m_data[121:90]  = {r_payload[11], r_payload[12], r_payload[13], r_payload[14]};
            n_m_data[153:122] = {r_payload[15], r_payload[16], r_payload[17], r_payload[18]};
            n_m_data[169:154] = r_ack;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delim <= StartDelimReset;
            r_end_delim   <= EndDelimReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CfgStartDelim: r_start_delim <= i_cfg_wdata;
                CfgEndDelim:   r_end_delim   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // packet control state, restarted after every tlast transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_crc      <= CrcInit;
            r_start_ok <= 1'b0;
        end else if (last_xfer) begin
            r_count    <= '0;
            r_crc      <= CrcInit;
            r_start_ok <= 1'b0;
        end else if (in_xfer) begin
            r_count    <= n_count;
            r_crc      <= n_crc;
            r_start_ok <= n_start_ok;
        end
    end

    // payload and received check bytes, no reset
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_check <= n_check;
            r_ack   <= n_ack;
        end
        if (pl_we) begin
            r_payload[pl_idx] <= s_axis_tdata;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (last_xfer) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (last_xfer) begin
            r_m_data <= n_m_data;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

`default_nettype wire

// ===== rtl/sfv_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfv_checker
// port-level checks on the result stream of the frame validator
// ----------------------------------------------------------------------------
module sfv_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         s_axis_tvalid,
    input  wire logic                         s_axis_tready,
    input  wire logic                         s_axis_tlast,
    input  wire logic                         m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    input  wire logic [sfv_pkg::OutDataW-1:0] m_axis_tdata
);
    import sfv_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a new result only follows a tlast transfer
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tvalid && s_axis_tready && s_axis_tlast) &&
        !(m_axis_tvalid && !m_axis_tready) |=> !m_axis_tvalid)
        else $error("result without a closing byte");

    // bad frames carry nothing but their status, padding always zero
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == ST_OK || m_axis_tdata[OutDataW-1:2] == '0) &&
                          m_axis_tdata[OutDataW-1:OutUsedW] == '0)
        else $error("nonzero fields in a rejected frame");

    // input stalls only while a result is waiting
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a waiting result");

endmodule

bind sensor_frame_validator sfv_checker u_sfv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
